// File: hw/rtl/scene_text_tokenizer_top_defines.svh
// Assertion macros for the scene text tokenizer.
// Included by the top level; no other dependencies.
`ifndef SCENE_TEXT_TOKENIZER_TOP_DEFINES_SVH
`define SCENE_TEXT_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define STT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define STT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/stt_pkg.sv
// Package for the scene text tokenizer: constants, mode codes, beat structs.
// No dependencies.
`timescale 1ns / 1ps

package stt_pkg;

    localparam int LINE_BITS  = 16;
    localparam int LINE_OUT_W = 16;
    localparam int QDEPTH     = 4;
    localparam int QADDR_W    = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_SKIP    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WORD    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_QSTART  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QUOTE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SLASH   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_COMMENT = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CSTAR   = 3'd6;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic       has_char;
        logic [7:0] token_char;
        logic       token_first;
        logic       token_end;
        logic       eof_token;
    } tok_t;

    typedef struct packed {
        logic                  two;
        tok_t                  tok_a;
        tok_t                  tok_b;
        logic [LINE_OUT_W-1:0] line_number;
    } step_t;

    function automatic tok_t mk_tok(input logic has, input logic [7:0] ch,
                                    input logic first, input logic fin,
                                    input logic eof);
        tok_t t;
        t.has_char    = has;
        t.token_char  = has ? ch : 8'h00;
        t.token_first = first;
        t.token_end   = fin;
        t.eof_token   = eof;
        return t;
    endfunction

endpackage

// File: hw/rtl/stt_in_if.sv
// Input channel interface: text byte and end-of-input mark with valid/ready.
// No dependencies.
`timescale 1ns / 1ps

interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_mark;

    modport source (output valid, output text_byte, output end_mark, input ready);
    modport sink   (input valid, input text_byte, input end_mark, output ready);
endinterface

// File: hw/rtl/stt_out_if.sv
// Output channel interface: token beats with valid/ready.
// No dependencies.
`timescale 1ns / 1ps

interface stt_out_if;
    logic        valid;
    logic        ready;
    logic        has_char;
    logic [7:0]  token_char;
    logic        token_first;
    logic        token_end;
    logic        eof_token;
    logic [15:0] line_number;
    logic        last_of_run;

    modport source (output valid, output has_char, output token_char,
                    output token_first, output token_end, output eof_token,
                    output line_number, output last_of_run, input ready);
    modport sink   (input valid, input has_char, input token_char,
                    input token_first, input token_end, input eof_token,
                    input line_number, input last_of_run, output ready);
endinterface

// File: hw/rtl/stt_front.sv
// Front end: accepts text beats, tracks scan mode and line count, classifies
// each byte into zero, one or two token beats. Depends on stt_pkg, stt_in_if.
`timescale 1ns / 1ps

module stt_front (
    input  logic          clk,
    input  logic          rst_n,
    stt_in_if.sink        in_ch,
    input  logic          q_full,
    output logic          push,
    output stt_pkg::step_t step
);
    import stt_pkg::*;

    logic [MODE_W-1:0]               mode_reg;
    logic [MODE_W-1:0]               mode_next;
    logic [LINE_BITS-1:0]            line_count_reg;
    logic [LINE_BITS-1:0]            line_count_next;
    logic [LINE_BITS+LINE_OUT_W-1:0] line_ext;
    logic                            accept;
    logic                            is_ws;
    logic                            is_nl;
    logic                            inc;
    logic                            emit;
    logic [MODE_W-1:0]               mode;
    logic [7:0]                      c;
    logic                            step_two;
    tok_t                            tok_a;
    tok_t                            tok_b;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign c           = in_ch.text_byte;
    assign is_ws       = c inside {8'h20, [8'h09:8'h0D]};
    assign is_nl       = (c == CH_LF) || (c == CH_CR);
    assign mode        = (mode_reg > MODE_CSTAR) ? MODE_SKIP : mode_reg;

    always_comb
    begin
        mode_next = mode;
        inc       = 1'b0;
        emit      = 1'b0;
        step_two  = 1'b0;
        tok_a     = mk_tok(1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        tok_b     = mk_tok(1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        if (in_ch.end_mark)
        begin
            emit      = 1'b1;
            tok_a     = mk_tok(1'b0, 8'h00,
                               !((mode == MODE_WORD) || (mode == MODE_QUOTE)), 1'b1, 1'b1);
            mode_next = MODE_SKIP;
        end
        else
        begin
            case (mode)
                MODE_WORD:
                begin
                    emit = 1'b1;
                    if (is_ws)
                    begin
                        inc       = is_nl;
                        tok_a     = mk_tok(1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
                        mode_next = MODE_SKIP;
                    end
                    else
                    begin
                        tok_a = mk_tok(1'b1, c, 1'b0, 1'b0, 1'b0);
                    end
                end
                MODE_QSTART:
                begin
                    emit = 1'b1;
                    if (c == CH_QUOTE)
                    begin
                        tok_a     = mk_tok(1'b0, 8'h00, 1'b1, 1'b1, 1'b0);
                        mode_next = MODE_SKIP;
                    end
                    else
                    begin
                        tok_a     = mk_tok(1'b1, c, 1'b1, 1'b0, 1'b0);
                        mode_next = MODE_QUOTE;
                    end
                end
                MODE_QUOTE:
                begin
                    emit = 1'b1;
                    if (c == CH_QUOTE)
                    begin
                        tok_a     = mk_tok(1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
                        mode_next = MODE_SKIP;
                    end
                    else
                    begin
                        tok_a = mk_tok(1'b1, c, 1'b0, 1'b0, 1'b0);
                    end
                end
                MODE_SLASH:
                begin
                    if (c == CH_STAR)
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    else
                    begin
                        emit     = 1'b1;
                        step_two = 1'b1;
                        tok_a    = mk_tok(1'b1, CH_SLASH, 1'b1, 1'b0, 1'b0);
                        if (is_ws)
                        begin
                            inc       = is_nl;
                            tok_b     = mk_tok(1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
                            mode_next = MODE_SKIP;
                        end
                        else
                        begin
                            tok_b     = mk_tok(1'b1, c, 1'b0, 1'b0, 1'b0);
                            mode_next = MODE_WORD;
                        end
                    end
                end
                MODE_COMMENT:
                begin
                    inc = is_nl;
                    if (c == CH_STAR)
                    begin
                        mode_next = MODE_CSTAR;
                    end
                end
                MODE_CSTAR:
                begin
                    inc = is_nl;
                    if (c == CH_SLASH)
                    begin
                        mode_next = MODE_SKIP;
                    end
                    else if (c != CH_STAR)
                    begin
                        mode_next = MODE_COMMENT;
                    end
                end
                default:
                begin
                    if (is_ws)
                    begin
                        inc = is_nl;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        mode_next = MODE_QSTART;
                    end
                    else if (c == CH_SLASH)
                    begin
                        mode_next = MODE_SLASH;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        tok_a     = mk_tok(1'b1, c, 1'b1, 1'b0, 1'b0);
                        mode_next = MODE_WORD;
                    end
                end
            endcase
        end
    end

    assign line_count_next = (inc && (line_count_reg != {LINE_BITS{1'b1}}))
                             ? line_count_reg + 1'b1 : line_count_reg;
    assign line_ext        = {{LINE_OUT_W{1'b0}}, line_count_next};
    assign step            = '{two:         step_two,
                               tok_a:       tok_a,
                               tok_b:       tok_b,
                               line_number: line_ext[LINE_OUT_W-1:0]};
    assign push            = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_SKIP;
            line_count_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            line_count_reg <= line_count_next;
        end
    end

endmodule

// File: hw/rtl/stt_queue.sv
// Short queue of classified steps between front and back ends.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  stt_pkg::step_t         push_data,
    input  logic                   pop,
    output stt_pkg::step_t         head,
    output logic                   head_valid,
    output logic                   full,
    output logic [stt_pkg::QCNT_W-1:0] count
);
    import stt_pkg::*;

    step_t              entry_reg [QDEPTH];
    logic [QADDR_W-1:0] wr_ptr_reg;
    logic [QADDR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign count      = count_reg;
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QADDR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QADDR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/stt_back.sv
// Back end: unrolls each queued step into one or two token beats through an
// output register. Depends on stt_pkg, stt_out_if.
`timescale 1ns / 1ps

module stt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  stt_pkg::step_t head,
    output logic           pop,
    stt_out_if.source      out_ch
);
    import stt_pkg::*;

    logic                  sel_reg;
    logic                  out_valid_reg;
    tok_t                  tok_reg;
    logic [LINE_OUT_W-1:0] line_reg;
    logic                  last_reg;
    logic                  load;
    logic                  last;
    tok_t                  tok_sel;

    assign load    = !out_valid_reg || out_ch.ready;
    assign last    = !head.two || sel_reg;
    assign tok_sel = sel_reg ? head.tok_b : head.tok_a;
    assign pop     = load && head_valid && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= head_valid;
            if (head_valid)
            begin
                sel_reg <= !last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            tok_reg  <= tok_sel;
            line_reg <= head.line_number;
            last_reg <= last;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.has_char    = tok_reg.has_char;
    assign out_ch.token_char  = tok_reg.token_char;
    assign out_ch.token_first = tok_reg.token_first;
    assign out_ch.token_end   = tok_reg.token_end;
    assign out_ch.eof_token   = tok_reg.eof_token;
    assign out_ch.line_number = line_reg;
    assign out_ch.last_of_run = last_reg;

endmodule

// File: hw/rtl/scene_text_tokenizer_top.sv
// Scene text tokenizer: splits a byte stream into word and string tokens,
// skipping whitespace and block comments and counting lines.
// Usage:
//   in_ch  carries one text byte per beat, or an end-of-input mark (end_mark).
//   out_ch carries token beats: a character, a start mark, an end mark or an
//          end-of-file token, with the line count and a last-of-run flag.
//   Each input byte yields zero, one or two output beats; whitespace between
//   tokens and comment bytes yield none.
// Path: a byte that yields a beat is written into a queue entry, then moves
//   into the output register, from which it shows on out_ch.
// Throughput: one input byte per cycle while the queue is not full; one output
//   beat per cycle while out_ch is ready, so two beats of one byte go out in turn.
// Stall: a four-entry queue decouples the ends; in_ch.ready drops only when
//   the queue is full. out_ch beats hold until taken.
// Reset: rst_n clears the scan mode to whitespace skipping, the line count
//   to zero and empties the queue and output register.
// Depends on stt_pkg, stt_in_if, stt_out_if, stt_front, stt_queue, stt_back.
`timescale 1ns / 1ps
`include "scene_text_tokenizer_top_defines.svh"

module scene_text_tokenizer_top (
    input  logic      clk,
    input  logic      rst_n,
    stt_in_if.sink    in_ch,
    stt_out_if.source out_ch
);
    import stt_pkg::*;

    step_t             step;
    step_t             head;
    logic              push;
    logic              pop;
    logic              head_valid;
    logic              q_full;
    logic [QCNT_W-1:0] q_count;

    stt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .push   (push),
        .step   (step)
    );

    stt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (step),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (q_full),
        .count      (q_count)
    );

    stt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_ch     (out_ch)
    );

    `STT_ASSERT_NOW(a_no_push_when_full, clk, rst_n, push, !q_full, "push into full queue")
    `STT_ASSERT_NOW(a_eof_ends_token, clk, rst_n, out_ch.valid && out_ch.eof_token, out_ch.token_end, "eof beat without token end")
    `STT_ASSERT_NOW(a_char_not_end, clk, rst_n, out_ch.valid && out_ch.has_char, !out_ch.token_end, "character beat marked as token end")
    `STT_ASSERT_NEXT(a_end_mark_queued, clk, rst_n, in_ch.valid && in_ch.ready && in_ch.end_mark, (q_count != '0) || out_ch.valid, "end mark produced no pending beat")

endmodule
